### rtl/overlapped_frame_windowing_assert.svh
// Assertion macros shared by the windowing RTL.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef OVERLAPPED_FRAME_WINDOWING_ASSERT_SVH
`define OVERLAPPED_FRAME_WINDOWING_ASSERT_SVH

// condition holds on every edge out of reset
`define OFW_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define OFW_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OFW_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ofw_pkg.sv
// Shared types and constants for the overlapped frame windowing block.
// No dependencies.
package ofw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 7;
  localparam int Q_SHIFT  = 15;

  localparam logic [CFG_W-1:0] FRAME_RST = 7'd64;
  localparam logic [CFG_W-1:0] HOP_RST   = 7'd32;
  localparam logic [CFG_W-1:0] FRAME_MIN = 7'd2;
  localparam logic [CFG_W-1:0] CNT_SAT   = 7'd127;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_PUSH = 1'b1
  } action_e;

  typedef enum logic {
    REG_FRAME_SIZE = 1'b0,
    REG_HOP_SIZE   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] windowed_sample;
    logic [IDX_W-1:0]    position;
    logic                last_in_frame;
  } out_word_t;

endpackage

### rtl/ofw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ofw_ram #(
  parameter int W = 16,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/ofw_front.sv
// Front end: config registers, coefficient/sample intake, frame trigger.
// Depends on ofw_pkg and the assertion macro header.
`include "overlapped_frame_windowing_assert.svh"

module ofw_front import ofw_pkg::*; #(
  parameter int FRAME_MAX = 64,
  localparam int AW = $clog2(FRAME_MAX)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [IDX_W-1:0]    window_index_i,
  input  logic [SAMPLE_W-1:0] coefficient_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                back_busy_i,
  input  logic                cmd_empty_i,
  input  logic                cmd_full_i,
  output logic                hist_we_o,
  output logic [AW-1:0]       hist_addr_o,
  output logic [SAMPLE_W-1:0] hist_data_o,
  output logic                win_we_o,
  output logic [AW-1:0]       win_addr_o,
  output logic [SAMPLE_W-1:0] win_data_o,
  output logic                cmd_push_o,
  output logic [AW-1:0]       cmd_start_o,
  output logic [CFG_W-1:0]    cmd_len_o
);

  localparam int SW = ((AW > CFG_W) ? AW : CFG_W) + 2;
  localparam logic [CFG_W-1:0] FMAX_CLIP = CFG_W'((FRAME_MAX > 127) ? 127 : FRAME_MAX);
  localparam logic [AW-1:0] WP_LAST = AW'(FRAME_MAX - 1);
  localparam logic [SW-1:0] FM_EXT = SW'(FRAME_MAX);

  logic [CFG_W-1:0] fs_q, hs_q, ssf_q, ssf_d;
  logic             primed_q, primed_d;
  logic [AW-1:0]    wp_q, wp_d;

  logic             acc, push_acc, load_acc, in_range, fire;
  logic [CFG_W-1:0] f_eff, h_eff, ssf_inc, need;
  logic [SW-1:0]    wpe, fe;

  assign in_stall_o = back_busy_i || !cmd_empty_i;
  assign acc      = in_valid_i && !in_stall_o;
  assign push_acc = acc && (action_i == ACT_PUSH);
  assign load_acc = acc && (action_i == ACT_LOAD);
  assign in_range = int'(window_index_i) < FRAME_MAX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FRAME_RST;
      hs_q <= HOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_SIZE: fs_q <= cfg_data_i;
        REG_HOP_SIZE:   hs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes
  always_comb begin
    if (fs_q < FRAME_MIN) f_eff = FRAME_MIN;
    else if (fs_q > FMAX_CLIP) f_eff = FMAX_CLIP;
    else f_eff = fs_q;
    if (hs_q == '0) h_eff = 7'd1;
    else if (hs_q > f_eff) h_eff = f_eff;
    else h_eff = hs_q;
  end

  assign ssf_inc = (ssf_q == CNT_SAT) ? CNT_SAT : ssf_q + 7'd1;
  assign need    = primed_q ? h_eff : f_eff;
  assign fire    = push_acc && (ssf_inc >= need);

  always_comb begin
    ssf_d    = ssf_q;
    primed_d = primed_q;
    wp_d     = wp_q;
    if (push_acc) begin
      ssf_d = fire ? '0 : ssf_inc;
      wp_d  = (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
      if (fire) primed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssf_q    <= '0;
      primed_q <= 1'b0;
      wp_q     <= '0;
    end else begin
      ssf_q    <= ssf_d;
      primed_q <= primed_d;
      wp_q     <= wp_d;
    end
  end

  // oldest sample of the frame sits f slots behind the next write slot
  assign wpe = SW'(wp_d);
  assign fe  = SW'(f_eff);
  assign cmd_start_o = (wpe >= fe) ? AW'(wpe - fe) : AW'(wpe + FM_EXT - fe);
  assign cmd_len_o   = f_eff;
  assign cmd_push_o  = fire;

  assign hist_we_o   = push_acc;
  assign hist_addr_o = wp_q;
  assign hist_data_o = sample_i;
  assign win_we_o    = load_acc && in_range;
  assign win_addr_o  = AW'(window_index_i);
  assign win_data_o  = coefficient_i;

  `OFW_CHECK(a_cmd_room, !(cmd_push_o && cmd_full_i), "frame command pushed into full queue")
  `OFW_CHECK_NXT(a_ssf_clear, fire, ssf_q == '0 && primed_q, "frame trigger did not rearm")
  `OFW_CHECK(a_wp_range, int'(wp_q) < FRAME_MAX, "history pointer out of range")

endmodule

### rtl/ofw_cmdq.sv
// Two-entry queue of frame commands between front and back.
// No dependencies.
module ofw_cmdq #(
  parameter int W = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         empty_o,
  output logic         full_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

### rtl/ofw_back.sv
// Back end: walks one frame through the RAMs, multiplies, buffers results.
// Depends on ofw_pkg and the assertion macro header.
`include "overlapped_frame_windowing_assert.svh"

module ofw_back import ofw_pkg::*; #(
  parameter int FRAME_MAX = 64,
  localparam int AW = $clog2(FRAME_MAX)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_empty_i,
  input  logic [AW-1:0]       cmd_start_i,
  input  logic [CFG_W-1:0]    cmd_len_i,
  output logic                cmd_pop_o,
  output logic                busy_o,
  output logic [AW-1:0]       hist_raddr_o,
  output logic [AW-1:0]       win_raddr_o,
  input  logic [SAMPLE_W-1:0] hist_rdata_i,
  input  logic [SAMPLE_W-1:0] win_rdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  localparam logic [2:0] OUT_DEPTH = 3'd4;
  localparam logic [AW-1:0] RP_LAST = AW'(FRAME_MAX - 1);

  back_state_e state_q, state_d;
  logic [CFG_W-1:0] p_q, len_q;
  logic [AW-1:0]    rp_q;
  logic             issue, last_issue, pop;
  logic [2:0]       cnt_q, ocnt_q;
  logic [1:0]       owr_q, ord_q;

  logic                    v1_q, v2_q, last1_q, last2_q;
  logic [IDX_W-1:0]        pos1_q, pos2_q;
  logic signed [SAMPLE_W-1:0] w_s, h_s;
  logic signed [2*SAMPLE_W-1:0] prod_q;
  out_word_t               ofifo_q [4];
  out_word_t               wword;

  assign last_issue = (p_q + 7'd1 == len_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!cmd_empty_i) state_d = BK_READ;
      BK_READ: if (issue && last_issue) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    issue     = 1'b0;
    busy_o    = 1'b0;
    case (state_q)
      BK_IDLE: cmd_pop_o = !cmd_empty_i;
      BK_READ: begin
        busy_o = 1'b1;
        issue  = (cnt_q < OUT_DEPTH);
      end
      default: ;
    endcase
  end

  assign hist_raddr_o = rp_q;
  assign win_raddr_o  = AW'(p_q);
  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      p_q     <= '0;
      len_q   <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ocnt_q  <= '0;
      owr_q   <= '0;
      ord_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        p_q   <= '0;
        len_q <= cmd_len_i;
        rp_q  <= cmd_start_i;
      end else if (issue) begin
        p_q  <= p_q + 7'd1;
        rp_q <= (rp_q == RP_LAST) ? '0 : rp_q + AW'(1);
      end
      // credits: issued and not yet taken downstream
      cnt_q  <= cnt_q + 3'(issue) - 3'(pop);
      v1_q   <= issue;
      v2_q   <= v1_q;
      ocnt_q <= ocnt_q + 3'(v2_q) - 3'(pop);
      if (v2_q) owr_q <= owr_q + 2'd1;
      if (pop)  ord_q <= ord_q + 2'd1;
    end
  end

  assign w_s = win_rdata_i;
  assign h_s = hist_rdata_i;

  always_ff @(posedge clk_i) begin
    pos1_q  <= p_q[IDX_W-1:0];
    last1_q <= last_issue;
    pos2_q  <= pos1_q;
    last2_q <= last1_q;
    prod_q  <= w_s * h_s;
    if (v2_q) ofifo_q[owr_q] <= wword;
  end

  always_comb begin
    wword.windowed_sample = prod_q[Q_SHIFT +: SAMPLE_W];
    wword.position        = pos2_q;
    wword.last_in_frame   = last2_q;
  end

  assign out_valid_o = (ocnt_q != 3'd0);
  assign out_word_o  = ofifo_q[ord_q];

  `OFW_CHECK(a_credit_bound, cnt_q <= OUT_DEPTH, "credit count overflow")
  `OFW_CHECK(a_ofifo_room, !(v2_q && ocnt_q == OUT_DEPTH), "result buffer overflow")
  `OFW_CHECK_IMP(a_issue_in_frame, issue, p_q < len_q, "read issued past frame end")

endmodule

### rtl/overlapped_frame_windowing.sv
// A frame-completing push queues a command; the back end pops it and issues reads, and
// the RAM read, product and result buffer are registered. Throughput: one word per cycle
// in a frame unless the output stalls; input stalls while a command waits or a frame
// is read. The rate is set by the single read port on the history and window RAMs.
// Reset (async, active low): frame_size 64, hop 32, counters cleared, not primed;
// RAM contents are undefined until written.
module overlapped_frame_windowing import ofw_pkg::*; #(
  parameter int FRAME_MAX = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [IDX_W-1:0]    window_index_i,
  input  logic [SAMPLE_W-1:0] coefficient_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] windowed_sample_o,
  output logic [IDX_W-1:0]    position_o,
  output logic                last_in_frame_o
);

  localparam int AW = $clog2(FRAME_MAX);
  localparam int CW = AW + CFG_W;

  logic                hist_we, win_we;
  logic [AW-1:0]       hist_waddr, win_waddr, hist_raddr, win_raddr;
  logic [SAMPLE_W-1:0] hist_wdata, win_wdata, hist_rdata, win_rdata;
  logic                cmd_push, cmd_pop, cmd_empty, cmd_full, back_busy;
  logic [AW-1:0]       cmd_start;
  logic [CFG_W-1:0]    cmd_len;
  logic [CW-1:0]       cmd_dout;
  out_word_t           out_word;

  // Front: takes words, writes the RAMs, decides when a frame is due.
  ofw_front #(.FRAME_MAX(FRAME_MAX)) u_front (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .action_i, .window_index_i, .coefficient_i, .sample_i,
    .back_busy_i (back_busy),
    .cmd_empty_i (cmd_empty),
    .cmd_full_i  (cmd_full),
    .hist_we_o   (hist_we),
    .hist_addr_o (hist_waddr),
    .hist_data_o (hist_wdata),
    .win_we_o    (win_we),
    .win_addr_o  (win_waddr),
    .win_data_o  (win_wdata),
    .cmd_push_o  (cmd_push),
    .cmd_start_o (cmd_start),
    .cmd_len_o   (cmd_len)
  );

  // Frame commands: start slot of the oldest sample and frame length.
  ofw_cmdq #(.W(CW)) u_cmdq (
    .clk_i, .rst_ni,
    .push_i  (cmd_push),
    .din_i   ({cmd_start, cmd_len}),
    .pop_i   (cmd_pop),
    .dout_o  (cmd_dout),
    .empty_o (cmd_empty),
    .full_o  (cmd_full)
  );

  // Sample history, circular, written at the front's write pointer.
  ofw_ram #(.W(SAMPLE_W), .D(FRAME_MAX)) u_hist_ram (
    .clk_i,
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Q15 window coefficients by frame position.
  ofw_ram #(.W(SAMPLE_W), .D(FRAME_MAX)) u_win_ram (
    .clk_i,
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  // Back: read, multiply, buffer; four-word result buffer on the output side.
  ofw_back #(.FRAME_MAX(FRAME_MAX)) u_back (
    .clk_i, .rst_ni,
    .cmd_empty_i  (cmd_empty),
    .cmd_start_i  (cmd_dout[CW-1:CFG_W]),
    .cmd_len_i    (cmd_dout[CFG_W-1:0]),
    .cmd_pop_o    (cmd_pop),
    .busy_o       (back_busy),
    .hist_raddr_o (hist_raddr),
    .win_raddr_o  (win_raddr),
    .hist_rdata_i (hist_rdata),
    .win_rdata_i  (win_rdata),
    .out_valid_o,
    .out_stall_i,
    .out_word_o   (out_word)
  );

  assign windowed_sample_o = out_word.windowed_sample;
  assign position_o        = out_word.position;
  assign last_in_frame_o   = out_word.last_in_frame;

endmodule
